// ----- hw/rtl/gwm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_SUBJECT = 2'd2,
    ACT_END     = 2'd3
  } action_e;

  localparam int unsigned CharW = 8;

  localparam logic [CharW-1:0] StarCh = 8'd42;  // '*'
  localparam logic [CharW-1:0] AnyCh  = 8'd63;  // '?'

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic             clear;    // drop the stored pattern
    logic             append;   // store ch in the first empty cell
    logic             subject;  // advance the active set on ch
    logic             rearm;    // reset active set to position zero
    logic [CharW-1:0] ch;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gwm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

// one pattern position: stored byte, fill flag and active bit
module gwm_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire gwm_pkg::ctrl_t ctrl_i,
  input  wire logic          arm_i,          // active value after re-arm
  input  wire logic          prev_filled_i,
  input  wire logic          carry_i,        // star closure from the left
  input  wire logic          adv_i,          // advance from the left
  output logic               filled_o,
  output logic               carry_o,
  output logic               adv_o,
  output logic               end_hit_o
);

  logic                          filled_q, filled_d;
  logic                          active_q, active_d;
  logic [gwm_pkg::CharW-1:0]     byte_q;
  logic                          load;
  logic                          closed;
  logic                          is_star;
  logic                          hit;

  assign load    = ctrl_i.append & prev_filled_i & ~filled_q;
  assign closed  = active_q | carry_i;
  assign is_star = (byte_q == gwm_pkg::StarCh);
  assign hit     = (byte_q == gwm_pkg::AnyCh) | (byte_q == ctrl_i.ch);

  assign carry_o   = closed & filled_q & is_star;
  assign adv_o     = closed & filled_q & ~is_star & hit;
  assign end_hit_o = closed & prev_filled_i & ~filled_q;
  assign filled_o  = filled_q;

  always_comb begin
    filled_d = filled_q;
    if (ctrl_i.clear) begin
      filled_d = 1'b0;
    end else if (load) begin
      filled_d = 1'b1;
    end
  end

  always_comb begin
    active_d = active_q;
    if (ctrl_i.rearm) begin
      active_d = arm_i;
    end else if (ctrl_i.subject) begin
      active_d = carry_o | adv_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
      active_q <= arm_i;
    end else begin
      filled_q <= filled_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= ctrl_i.ch;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/glob_wildcard_matcher_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Whole-string glob matcher ('*' any run, '?' any byte, else literal). Send a
// clear, then the pattern one byte per transaction (append), then the subject
// one byte per transaction, then an end transaction; only the end transaction
// produces a result {overflow, matched}, and it re-arms the pattern for the
// next subject. Appending also restarts a subject in progress. The input accepts
// one transaction per cycle while s_axis_tready is high; a result is registered into
// the output register, or into the skid while a result waits. The pattern lives
// in a row of PAT_MAX cells, each holding one byte and one active bit; star
// closure ripples through the row within the cycle, which sets the clock limit.
// A two-deep output stage (register plus skid) lets the input keep flowing
// while a result waits; s_axis_tready drops only when both are full.
module glob_wildcard_matcher_unit #(
  parameter int unsigned PAT_MAX = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] ch
  input  wire logic [1:0] s_axis_tuser,   // [1:0] action
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [0] matched, [1] overflow, [7:2] zero
);

  // input side
  logic           in_acc;
  gwm_pkg::ctrl_t ctrl;
  logic           is_end;

  // cell chain, index i is the link into cell i, index PAT_MAX the tail
  logic [PAT_MAX:0]   fill;
  logic [PAT_MAX:0]   carry;
  logic [PAT_MAX:0]   adv;
  logic [PAT_MAX-1:0] end_hit;

  // accepting position beyond the last cell
  logic tail_q, tail_d;
  logic tail_closed;
  logic tail_hit;

  logic overflow_q, overflow_d;
  logic res_matched;

  // output register and skid
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_q, out_d;
  logic       skid_valid_q, skid_valid_d;
  logic [1:0] skid_q, skid_d;
  logic       pop;

  assign s_axis_tready = ~skid_valid_q;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    ctrl         = '0;
    ctrl.ch      = s_axis_tdata;
    is_end       = 1'b0;
    if (in_acc) begin
      case (gwm_pkg::action_e'(s_axis_tuser))
        gwm_pkg::ACT_CLEAR: begin
          ctrl.clear = 1'b1;
          ctrl.rearm = 1'b1;
        end
        gwm_pkg::ACT_APPEND: begin
          ctrl.append = 1'b1;
          ctrl.rearm  = 1'b1;
        end
        gwm_pkg::ACT_SUBJECT: begin
          ctrl.subject = 1'b1;
        end
        gwm_pkg::ACT_END: begin
          ctrl.rearm = 1'b1;
          is_end     = 1'b1;
        end
        default: begin
          ctrl = ctrl;
        end
      endcase
    end
  end

  // nothing enters the first cell from the left; position zero is always "after" a fill
  assign fill[0]  = 1'b1;
  assign carry[0] = 1'b0;
  assign adv[0]   = 1'b0;

  for (genvar i = 0; i < PAT_MAX; i++) begin : g_cell
    gwm_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .arm_i         (i == 0),
      .prev_filled_i (fill[i]),
      .carry_i       (carry[i]),
      .adv_i         (adv[i]),
      .filled_o      (fill[i+1]),
      .carry_o       (carry[i+1]),
      .adv_o         (adv[i+1]),
      .end_hit_o     (end_hit[i])
    );
  end

  // tail never holds a star, so it only takes advances
  assign tail_closed = tail_q | carry[PAT_MAX];
  assign tail_hit    = tail_closed & fill[PAT_MAX];

  always_comb begin
    tail_d = tail_q;
    if (ctrl.rearm) begin
      tail_d = 1'b0;
    end else if (ctrl.subject) begin
      tail_d = adv[PAT_MAX];
    end
  end

  // append with every cell filled drops the byte and flags overflow
  always_comb begin
    overflow_d = overflow_q;
    if (ctrl.clear) begin
      overflow_d = 1'b0;
    end else if (ctrl.append && fill[PAT_MAX]) begin
      overflow_d = 1'b1;
    end
  end

  assign res_matched = ((|end_hit) | tail_hit) & ~overflow_q;

  assign pop = out_valid_q & m_axis_tready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (is_end) begin
      if (!out_valid_q || pop) begin
        out_valid_d = 1'b1;
        out_d       = {overflow_q, res_matched};
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = {overflow_q, res_matched};
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q       <= 1'b0;
      overflow_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      tail_q       <= tail_d;
      overflow_q   <= overflow_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

  // skid only fills behind a waiting result
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while the output register is empty");

  // an overflowed pattern never reports a match
  a_ovf_no_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q[1] |-> !out_q[0])
    else $error("match reported with overflow set");

  // clear drops the overflow flag
  a_clear_ovf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> !overflow_q)
    else $error("overflow survives a clear");

  // re-arm leaves the tail inactive
  a_rearm_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rearm |=> !tail_q)
    else $error("tail active after re-arm");

endmodule

`default_nettype wire
